// ===== rtl/rasc_pkg.sv =====
// shared types and constants for the rational add/subtract/compare block
package rasc_pkg;

    // operation codes
    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_SUB = 2'd1;
    localparam logic [1:0] FUNC_CMP = 2'd2;

    // fixed field widths
    localparam int FUNC_W = 2;
    localparam int NUM_W  = 33;
    localparam int DEN_W  = 32;

    // sequencer states
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_EVAL = 7'b0000100,
        ST_GCD  = 7'b0001000,
        ST_DIVN = 7'b0010000,
        ST_DIVD = 7'b0100000,
        ST_DONE = 7'b1000000
    } rasc_state_t;

endpackage

// ===== rtl/rasc_if.sv =====
// operand and result channel interfaces

interface rasc_op_if import rasc_pkg::*; #(parameter int IN_WIDTH = 16) ();
    logic                       valid;
    logic                       ready;
    logic [FUNC_W-1:0]          func;
    logic signed [IN_WIDTH-1:0] first_num;
    logic signed [IN_WIDTH-1:0] first_den;
    logic signed [IN_WIDTH-1:0] second_num;
    logic signed [IN_WIDTH-1:0] second_den;

    modport source (
        output valid, func, first_num, first_den, second_num, second_den,
        input  ready
    );
    modport sink (
        input  valid, func, first_num, first_den, second_num, second_den,
        output ready
    );
endinterface

interface rasc_res_if import rasc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [NUM_W-1:0] result_num;
    logic signed [DEN_W-1:0] result_den;
    logic                    is_equal;
    logic                    zero_den_error;

    modport source (
        output valid, result_num, result_den, is_equal, zero_den_error,
        input  ready
    );
    modport sink (
        input  valid, result_num, result_den, is_equal, zero_den_error,
        output ready
    );
endinterface

// ===== rtl/rasc_gcd.sv =====
// binary gcd unit, one compare/subtract or shift step per cycle
module rasc_gcd #(
    parameter int W = 33
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a_in,
    input  logic [W-1:0] b_in,
    output logic         done,
    output logic [W-1:0] g
);

    localparam int KW = $clog2(W + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [W-1:0]  a_reg;
    logic [W-1:0]  b_reg;
    logic [KW-1:0] k_reg;
    logic [W-1:0]  g_reg;
    logic          same;

    assign same = (a_reg == b_reg);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && same)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // stein steps: strip common twos, strip lone twos, subtract odd values
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a_in;
            b_reg <= b_in;
            k_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (same)
            begin
                g_reg <= a_reg << k_reg;
            end
            else if (!a_reg[0] && !b_reg[0])
            begin
                a_reg <= a_reg >> 1;
                b_reg <= b_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end
            else if (!a_reg[0])
            begin
                a_reg <= a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_reg <= b_reg >> 1;
            end
            else if (a_reg > b_reg)
            begin
                a_reg <= a_reg - b_reg;
            end
            else
            begin
                b_reg <= b_reg - a_reg;
            end
        end
    end

    assign done = done_reg;
    assign g    = g_reg;

endmodule

// ===== rtl/rasc_div.sv =====
// restoring divider, one quotient bit per cycle
module rasc_div #(
    parameter int W = 33
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  dsr_reg;
    logic [W:0]    trial;
    logic          fits;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift in one dividend bit, subtract when the divisor fits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_reg <= trial[W-1:0];
            end
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/rational_add_sub_compare_top.sv =====
// rational add/subtract/compare: top level with sequencer and shared multiplier
// sequence: an error or unused code goes straight to the result; compare multiplies
// and evaluates; add/subtract (unless the sum is zero) then runs the gcd and divides
//   numerator and denominator by it, and the binary gcd takes one step per cycle
// one item in flight: ready only when idle, next item after the result is taken
// asynchronous active-low reset returns the sequencer to idle, no result pending
module rational_add_sub_compare_top import rasc_pkg::*; #(
    parameter int IN_WIDTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    rasc_op_if.sink   operands,
    rasc_res_if.source result
);

    localparam int PRW = 2 * IN_WIDTH;
    localparam int PW  = PRW + 1;
    localparam int OW  = (PW > NUM_W) ? PW : NUM_W;

    rasc_state_t state_reg;
    rasc_state_t state_next;

    logic [1:0]          mcnt_reg;
    logic [FUNC_W-1:0]   op_reg;
    logic [IN_WIDTH-1:0] n1_mag_reg, d1_mag_reg, n2_mag_reg, d2_mag_reg;
    logic                n1_neg_reg, d1_neg_reg, n2_neg_reg, d2_neg_reg;
    logic [PRW-1:0]      p_mag_reg, q_mag_reg, d_mag_reg;
    logic [PW-1:0]       num_mag_reg;
    logic                num_neg_reg;
    logic [PW-1:0]       num_q_reg;
    logic signed [NUM_W-1:0] res_num_reg;
    logic signed [DEN_W-1:0] res_den_reg;
    logic                eq_reg;
    logic                err_reg;

    logic                accept;
    logic                n1_neg, d1_neg, n2_neg, d2_neg;
    logic [IN_WIDTH-1:0] n1_mag, d1_mag, n2_mag, d2_mag;
    logic                zero_den;
    logic                bad_func;
    logic [IN_WIDTH-1:0] mul_a, mul_b;
    logic [PRW-1:0]      product;
    logic                p_neg, q_neg_raw, q_neg;
    logic [PW-1:0]       p_ext, q_ext;
    logic [PW-1:0]       sum_mag;
    logic                sum_neg;
    logic                cmp_eq;
    logic                gcd_start, gcd_done;
    logic [PW-1:0]       gcd_g;
    logic                div_start, div_done;
    logic [PW-1:0]       div_dividend, div_quo;
    logic [OW-1:0]       num_twos, den_twos;

    // magnitude and sign conversion
    function automatic logic [OW-1:0] to_twos(input logic [PW-1:0] mag, input logic neg);
        logic [OW-1:0] ext;
        ext = OW'(mag);
        return neg ? (~ext + 1'b1) : ext;
    endfunction

    assign accept = operands.valid && operands.ready;

    // operand split into sign and magnitude
    always_comb
    begin
        n1_neg = operands.first_num[IN_WIDTH-1];
        d1_neg = operands.first_den[IN_WIDTH-1];
        n2_neg = operands.second_num[IN_WIDTH-1];
        d2_neg = operands.second_den[IN_WIDTH-1];
        n1_mag = n1_neg ? (~operands.first_num + 1'b1) : operands.first_num;
        d1_mag = d1_neg ? (~operands.first_den + 1'b1) : operands.first_den;
        n2_mag = n2_neg ? (~operands.second_num + 1'b1) : operands.second_num;
        d2_mag = d2_neg ? (~operands.second_den + 1'b1) : operands.second_den;
        zero_den = (operands.first_den == '0) || (operands.second_den == '0);
        bad_func = !((operands.func == FUNC_ADD) || (operands.func == FUNC_SUB)
                     || (operands.func == FUNC_CMP));
    end

    // shared multiplier: cross products, then denominator product
    always_comb
    begin
        if (mcnt_reg == 2'd0)
        begin
            mul_a = n1_mag_reg;
            mul_b = d2_mag_reg;
        end
        else if (mcnt_reg == 2'd1)
        begin
            mul_a = n2_mag_reg;
            mul_b = d1_mag_reg;
        end
        else
        begin
            mul_a = d1_mag_reg;
            mul_b = d2_mag_reg;
        end
        product = PRW'(mul_a) * PRW'(mul_b);
    end

    // signed-magnitude sum of the cross products and equality test
    always_comb
    begin
        p_neg     = (p_mag_reg != '0) && (n1_neg_reg ^ d2_neg_reg);
        q_neg_raw = (q_mag_reg != '0) && (n2_neg_reg ^ d1_neg_reg);
        q_neg     = (q_mag_reg != '0) && (q_neg_raw ^ (op_reg == FUNC_SUB));
        p_ext     = PW'(p_mag_reg);
        q_ext     = PW'(q_mag_reg);
        if (p_neg == q_neg)
        begin
            sum_mag = p_ext + q_ext;
            sum_neg = p_neg;
        end
        else if (p_ext >= q_ext)
        begin
            sum_mag = p_ext - q_ext;
            sum_neg = p_neg;
        end
        else
        begin
            sum_mag = q_ext - p_ext;
            sum_neg = q_neg;
        end
        if (sum_mag == '0)
        begin
            sum_neg = 1'b0;
        end
        cmp_eq = (p_mag_reg == q_mag_reg) && ((p_mag_reg == '0) || (p_neg == q_neg_raw));
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (zero_den || bad_func) ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mcnt_reg == 2'd2)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (op_reg == FUNC_CMP || sum_mag == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (gcd_done)
                begin
                    state_next = ST_DIVN;
                end
            end
            ST_DIVN:
            begin
                if (div_done)
                begin
                    state_next = ST_DIVD;
                end
            end
            ST_DIVD:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_MUL)
            begin
                mcnt_reg <= mcnt_reg + 1'b1;
            end
            else
            begin
                mcnt_reg <= '0;
            end
        end
    end

    // unit hand-off
    assign gcd_start    = (state_reg == ST_EVAL) && (op_reg != FUNC_CMP) && (sum_mag != '0);
    assign div_start    = ((state_reg == ST_GCD) && gcd_done) ||
                          ((state_reg == ST_DIVN) && div_done);
    assign div_dividend = (state_reg == ST_GCD) ? num_mag_reg : PW'(d_mag_reg);

    assign num_twos = to_twos(num_q_reg, num_neg_reg);
    assign den_twos = to_twos(div_quo, d1_neg_reg ^ d2_neg_reg);

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_reg      <= operands.func;
                    n1_mag_reg  <= n1_mag;
                    d1_mag_reg  <= d1_mag;
                    n2_mag_reg  <= n2_mag;
                    d2_mag_reg  <= d2_mag;
                    n1_neg_reg  <= n1_neg;
                    d1_neg_reg  <= d1_neg;
                    n2_neg_reg  <= n2_neg;
                    d2_neg_reg  <= d2_neg;
                    res_num_reg <= '0;
                    res_den_reg <= '0;
                    eq_reg      <= 1'b0;
                    err_reg     <= zero_den;
                end
            end
            ST_MUL:
            begin
                if (mcnt_reg == 2'd0)
                begin
                    p_mag_reg <= product;
                end
                else if (mcnt_reg == 2'd1)
                begin
                    q_mag_reg <= product;
                end
                else
                begin
                    d_mag_reg <= product;
                end
            end
            ST_EVAL:
            begin
                num_mag_reg <= sum_mag;
                num_neg_reg <= sum_neg;
                if (op_reg == FUNC_CMP || sum_mag == '0)
                begin
                    res_num_reg <= '0;
                    res_den_reg <= DEN_W'(1);
                    eq_reg      <= (op_reg == FUNC_CMP) && cmp_eq;
                end
            end
            ST_DIVN:
            begin
                if (div_done)
                begin
                    num_q_reg <= div_quo;
                end
            end
            ST_DIVD:
            begin
                if (div_done)
                begin
                    res_num_reg <= num_twos[NUM_W-1:0];
                    res_den_reg <= den_twos[DEN_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    rasc_gcd #(
        .W (PW)
    ) u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .a_in  (sum_mag),
        .b_in  (PW'(d_mag_reg)),
        .done  (gcd_done),
        .g     (gcd_g)
    );

    rasc_div #(
        .W (PW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (gcd_g),
        .done     (div_done),
        .quotient (div_quo)
    );

    // channel outputs
    assign operands.ready        = (state_reg == ST_IDLE);
    assign result.valid          = (state_reg == ST_DONE);
    assign result.result_num     = res_num_reg;
    assign result.result_den     = res_den_reg;
    assign result.is_equal       = eq_reg;
    assign result.zero_den_error = err_reg;

endmodule

// ===== rtl/rasc_checker.sv =====
// port-level checks for the rational add/subtract/compare block and its bind
module rasc_checker import rasc_pkg::*; (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [NUM_W-1:0] result_num,
    input logic signed [DEN_W-1:0] result_den,
    input logic                    is_equal,
    input logic                    zero_den_error
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_num) && $stable(result_den))
        else $error("result changed while stalled");

    // one item in flight: never ready while a result waits
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("ready while result pending");

    // busy right after an item is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accept");

    // zero denominator clears the other fields
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_den_error |->
            (result_num == '0) && (result_den == '0) && !is_equal)
        else $error("error result not cleared");

    // equal flag only on a compare result
    a_eq_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_equal |->
            (result_num == '0) && (result_den == DEN_W'(1)) && !zero_den_error)
        else $error("equal flag on a non-compare result");

endmodule

bind rational_add_sub_compare_top rasc_checker u_rasc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (operands.valid),
    .in_ready       (operands.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .result_num     (result.result_num),
    .result_den     (result.result_den),
    .is_equal       (result.is_equal),
    .zero_den_error (result.zero_den_error)
);
